### sv/fvps_pkg.sv
// shared types, constants and sine table builder for the fourier volume phase shift core
package fvps_pkg;

  // sample and coefficient formats
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_FRAC   = 24;
  // unsigned magnitude of a table entry (sine of a quarter turn is one)
  localparam int COEF_MAG_W  = COEF_FRAC + 1;
  // signed coefficient after quadrant sign
  localparam int COEF_W      = COEF_FRAC + 2;

  // defaults for the top level parameters
  localparam int PHASE_BITS_DEF = 32;
  localparam int TABLE_BITS_DEF = 10;
  localparam int MAX_DIM_DEF    = 4096;

  // configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_COLS_W  = 12;
  localparam int CFG_ROWS_W  = 13;
  localparam int CFG_PLNS_W  = 13;
  // width for size compares, one bit above the widest size register
  localparam int DIM_CMP_W   = CFG_ROWS_W + 1;

  // depth of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;

  // pi/2 in Q30 for the table series
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STEP_X  = 3'd0,
    CFG_STEP_Y  = 3'd1,
    CFG_STEP_Z  = 3'd2,
    CFG_COLUMNS = 3'd3,
    CFG_ROWS    = 3'd4,
    CFG_PLANES  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] shifted_re;
    logic signed [SAMPLE_BITS-1:0] shifted_im;
    logic                          last_of_volume;
  } result_t;

  // quarter-wave sine entry i for a table of 2^tb points per turn,
  // fixed-point taylor series up to x^17 in truncating q30 steps
  function automatic logic [COEF_MAG_W-1:0] sine_entry(input int i, input int tb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned half_q;
    longint          sum;
    longint unsigned rounded;
    half_q = (64'd1 << (tb - 2)) >> 1;
    x      = (64'(i) * HALF_PI_Q30 + half_q) >> (tb - 2);
    x2     = (x * x) >> 30;
    term   = x;
    sum    = longint'(x);
    term   = ((term * x2) >> 30) / 6;
    sum    = sum - longint'(term);
    term   = ((term * x2) >> 30) / 20;
    sum    = sum + longint'(term);
    term   = ((term * x2) >> 30) / 42;
    sum    = sum - longint'(term);
    term   = ((term * x2) >> 30) / 72;
    sum    = sum + longint'(term);
    term   = ((term * x2) >> 30) / 110;
    sum    = sum - longint'(term);
    term   = ((term * x2) >> 30) / 156;
    sum    = sum + longint'(term);
    term   = ((term * x2) >> 30) / 210;
    sum    = sum - longint'(term);
    term   = ((term * x2) >> 30) / 272;
    sum    = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    rounded = (longint'(sum) + (64'd1 << (30 - COEF_FRAC - 1))) >> (30 - COEF_FRAC);
    return COEF_MAG_W'(rounded);
  endfunction

endpackage

### sv/fourier_volume_phase_shift_core.sv
// top level of the fourier volume phase shift core
//
// Applies the shift theorem to a half-spectrum volume streamed in raster order
// (column fastest, then row, then plane). Each coefficient on the sample channel
// is rotated by minus column*step_x + row*step_y + plane*step_z turns and leaves
// on the result channel, rounded and saturated, with last_of_volume set on the
// final coefficient of the volume.
// Both channels are valid/stall: a transaction moves at a clock edge with valid
// high and stall low. Steps and sizes are to be written through the cfg port while
// the block is idle, which the block does not enforce; a size of zero acts as one.
// Path: an accepted sample is held in the queue, then registered in the lookup,
// multiply and sum stages and, rounded and clipped, in the output register.
// Throughput: one coefficient per cycle while result_stall is low, set by the four-stage rotation pipeline.
// When the receiver stalls, the output register holds its transaction, the
// pipeline fills, then the four-entry queue fills and sample_stall rises.
// Synchronous reset returns the position and phases to the volume origin, sets
// steps to zero and sizes to one, and empties the queue and pipeline.
module fourier_volume_phase_shift_core
  import fvps_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int TABLE_BITS = TABLE_BITS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result
);

  localparam int SAMPLE_W = $bits(sample_t);
  localparam int ITEM_W   = SAMPLE_W + TABLE_BITS + 1;

  logic                  front_push;
  sample_t               front_sample;
  logic [TABLE_BITS-1:0] front_idx;
  logic                  front_last;
  logic                  queue_full;
  logic                  queue_not_empty;
  logic                  queue_pop;
  logic [ITEM_W-1:0]     queue_out;
  sample_t               back_sample;
  logic [TABLE_BITS-1:0] back_idx;
  logic                  back_last;

  // position tracking and phase accumulation
  fvps_front #(
    .PHASE_BITS (PHASE_BITS),
    .TABLE_BITS (TABLE_BITS),
    .MAX_DIM    (MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .queue_full   (queue_full),
    .item_push    (front_push),
    .item_sample  (front_sample),
    .item_idx     (front_idx),
    .item_last    (front_last)
  );

  // decoupling queue
  fvps_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data ({front_sample, front_idx, front_last}),
    .full      (queue_full),
    .pop       (queue_pop),
    .not_empty (queue_not_empty),
    .pop_data  (queue_out)
  );

  assign back_sample = queue_out[ITEM_W-1 -: SAMPLE_W];
  assign back_idx    = queue_out[TABLE_BITS:1];
  assign back_last   = queue_out[0];

  // rotation pipeline
  fvps_back #(
    .TABLE_BITS (TABLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (queue_not_empty),
    .item_pop     (queue_pop),
    .item_sample  (back_sample),
    .item_idx     (back_idx),
    .item_last    (back_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### sv/fvps_front.sv
// front end: configuration registers, volume position counters and phase accumulation
module fvps_front
  import fvps_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int TABLE_BITS = TABLE_BITS_DEF,
  parameter int MAX_DIM    = MAX_DIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  sample_t                sample,
  input  logic                   queue_full,
  output logic                   item_push,
  output sample_t                item_sample,
  output logic [TABLE_BITS-1:0]  item_idx,
  output logic                   item_last
);

  localparam int IDX_W   = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int SHIFT   = PHASE_BITS - TABLE_BITS;
  localparam logic [DIM_CMP_W-1:0] COL_TOP = DIM_CMP_W'(MAX_DIM / 2 + 1);
  localparam logic [DIM_CMP_W-1:0] DIM_TOP = DIM_CMP_W'(MAX_DIM);
  localparam logic [PHASE_BITS-1:0] PHASE_HALF = PHASE_BITS'(1) << (SHIFT - 1);

  logic [PHASE_BITS-1:0] step_x;
  logic [PHASE_BITS-1:0] step_y;
  logic [PHASE_BITS-1:0] step_z;
  logic [CFG_COLS_W-1:0] columns;
  logic [CFG_ROWS_W-1:0] rows;
  logic [CFG_PLNS_W-1:0] planes;

  logic [IDX_W-1:0]      column_index;
  logic [IDX_W-1:0]      row_index;
  logic [IDX_W-1:0]      plane_index;
  logic [PHASE_BITS-1:0] plane_phase;
  logic [PHASE_BITS-1:0] row_phase;
  logic [PHASE_BITS-1:0] point_phase;

  logic [DIM_CMP_W-1:0]  ncol;
  logic [DIM_CMP_W-1:0]  nrow;
  logic [DIM_CMP_W-1:0]  npln;
  logic                  col_end;
  logic                  row_end;
  logic                  pln_end;
  logic                  accept;
  logic [PHASE_BITS-1:0] phase_rounded;
  logic [PHASE_BITS-1:0] row_phase_next;
  logic [PHASE_BITS-1:0] plane_phase_next;

  function automatic logic [DIM_CMP_W-1:0] clamp_count(input logic [DIM_CMP_W-1:0] v,
                                                       input logic [DIM_CMP_W-1:0] top);
    logic [DIM_CMP_W-1:0] r;
    if (v == '0) begin
      r = DIM_CMP_W'(1);
    end else if (v > top) begin
      r = top;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_x  <= '0;
      step_y  <= '0;
      step_z  <= '0;
      columns <= CFG_COLS_W'(1);
      rows    <= CFG_ROWS_W'(1);
      planes  <= CFG_PLNS_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STEP_X:  step_x  <= cfg_data[PHASE_BITS-1:0];
        CFG_STEP_Y:  step_y  <= cfg_data[PHASE_BITS-1:0];
        CFG_STEP_Z:  step_z  <= cfg_data[PHASE_BITS-1:0];
        CFG_COLUMNS: columns <= cfg_data[CFG_COLS_W-1:0];
        CFG_ROWS:    rows    <= cfg_data[CFG_ROWS_W-1:0];
        CFG_PLANES:  planes  <= cfg_data[CFG_PLNS_W-1:0];
        default:     ;
      endcase
    end
  end

  // effective sizes and wrap detection
  always_comb begin
    ncol = clamp_count(DIM_CMP_W'(columns), COL_TOP);
    nrow = clamp_count(DIM_CMP_W'(rows), DIM_TOP);
    npln = clamp_count(DIM_CMP_W'(planes), DIM_TOP);
    col_end = (DIM_CMP_W'(column_index) + DIM_CMP_W'(1)) >= ncol;
    row_end = (DIM_CMP_W'(row_index) + DIM_CMP_W'(1)) >= nrow;
    pln_end = (DIM_CMP_W'(plane_index) + DIM_CMP_W'(1)) >= npln;
    row_phase_next   = row_phase + step_y;
    plane_phase_next = plane_phase + step_z;
  end

  // table index is the phase rounded to the nearest table point
  assign phase_rounded = point_phase + PHASE_HALF;

  assign sample_stall = queue_full;
  assign accept       = sample_valid && !queue_full;

  assign item_push   = accept;
  assign item_sample = sample;
  assign item_idx    = phase_rounded[PHASE_BITS-1:SHIFT];
  assign item_last   = col_end && row_end && pln_end;

  // raster position and phase advance per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      plane_index  <= '0;
      plane_phase  <= '0;
      row_phase    <= '0;
      point_phase  <= '0;
    end else if (accept) begin
      priority if (!col_end) begin
        column_index <= column_index + IDX_W'(1);
        point_phase  <= point_phase + step_x;
      end else if (!row_end) begin
        column_index <= '0;
        row_index    <= row_index + IDX_W'(1);
        row_phase    <= row_phase_next;
        point_phase  <= row_phase_next;
      end else if (!pln_end) begin
        column_index <= '0;
        row_index    <= '0;
        plane_index  <= plane_index + IDX_W'(1);
        plane_phase  <= plane_phase_next;
        row_phase    <= plane_phase_next;
        point_phase  <= plane_phase_next;
      end else begin
        column_index <= '0;
        row_index    <= '0;
        plane_index  <= '0;
        plane_phase  <= '0;
        row_phase    <= '0;
        point_phase  <= '0;
      end
    end
  end

endmodule

### sv/fvps_queue.sv
// short queue that decouples the front end from the rotation pipeline
module fvps_queue
  import fvps_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### sv/fvps_back.sv
// back end: sine/cosine lookup, complex rotation, rounding and saturation
module fvps_back
  import fvps_pkg::*;
#(
  parameter int TABLE_BITS = TABLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_pop,
  input  sample_t               item_sample,
  input  logic [TABLE_BITS-1:0] item_idx,
  input  logic                  item_last,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam int ROM_W   = TABLE_BITS - 1;
  localparam int PROD_W  = SAMPLE_BITS + COEF_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int Q_W     = ACC_W - COEF_FRAC;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0] SAT_LO = -SAT_HI - Q_W'(1);

  // quarter-wave table, constant per entry
  logic [COEF_MAG_W-1:0] sine_rom [QUARTER + 1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, TABLE_BITS);
  end

  logic [TABLE_BITS-1:0] cos_idx;
  logic [ROM_W-1:0]      sin_addr;
  logic [ROM_W-1:0]      cos_addr;
  logic signed [COEF_W-1:0] sin_val;
  logic signed [COEF_W-1:0] cos_val;

  // stage valids and advance enables
  logic s1_valid;
  logic s2_valid;
  logic s3_valid;
  logic s1_en;
  logic s2_en;
  logic s3_en;
  logic out_en;

  // stage 1: lookup
  logic signed [SAMPLE_BITS-1:0] s1_re;
  logic signed [SAMPLE_BITS-1:0] s1_im;
  logic signed [COEF_W-1:0]      s1_s;
  logic signed [COEF_W-1:0]      s1_c;
  logic                          s1_last;
  // stage 2: products
  logic signed [PROD_W-1:0]      s2_rc;
  logic signed [PROD_W-1:0]      s2_is;
  logic signed [PROD_W-1:0]      s2_ic;
  logic signed [PROD_W-1:0]      s2_rs;
  logic                          s2_last;
  // stage 3: sums
  logic signed [ACC_W-1:0]       s3_acc_re;
  logic signed [ACC_W-1:0]       s3_acc_im;
  logic                          s3_last;

  logic signed [ACC_W-1:0]       round_re;
  logic signed [ACC_W-1:0]       round_im;
  logic signed [Q_W-1:0]         q_re;
  logic signed [Q_W-1:0]         q_im;
  logic signed [SAMPLE_BITS-1:0] sat_re;
  logic signed [SAMPLE_BITS-1:0] sat_im;

  function automatic logic [ROM_W-1:0] rom_addr(input logic [TABLE_BITS-1:0] idx);
    logic [ROM_W-1:0] r;
    r = ROM_W'(idx[TABLE_BITS-3:0]);
    return idx[TABLE_BITS-2] ? (ROM_W'(QUARTER) - r) : r;
  endfunction

  // quadrant fold of the table index
  always_comb begin
    cos_idx  = item_idx + TABLE_BITS'(QUARTER);
    sin_addr = rom_addr(item_idx);
    cos_addr = rom_addr(cos_idx);
    sin_val  = item_idx[TABLE_BITS-1] ? -COEF_W'(sine_rom[sin_addr])
                                      : COEF_W'(sine_rom[sin_addr]);
    cos_val  = cos_idx[TABLE_BITS-1]  ? -COEF_W'(sine_rom[cos_addr])
                                      : COEF_W'(sine_rom[cos_addr]);
  end

  // a stage moves when its successor has room
  assign out_en   = !result_valid || !result_stall;
  assign s3_en    = !s3_valid || out_en;
  assign s2_en    = !s2_valid || s3_en;
  assign s1_en    = !s1_valid || s2_en;
  assign item_pop = item_valid && s1_en;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= item_valid;
      end
      if (s2_en) begin
        s2_valid <= s1_valid;
      end
      if (s3_en) begin
        s3_valid <= s2_valid;
      end
      if (out_en) begin
        result_valid <= s3_valid;
      end
    end
  end

  // lookup stage
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_re   <= item_sample.sample_re;
      s1_im   <= item_sample.sample_im;
      s1_s    <= sin_val;
      s1_c    <= cos_val;
      s1_last <= item_last;
    end
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_rc   <= PROD_W'(s1_re) * PROD_W'(s1_c);
      s2_is   <= PROD_W'(s1_im) * PROD_W'(s1_s);
      s2_ic   <= PROD_W'(s1_im) * PROD_W'(s1_c);
      s2_rs   <= PROD_W'(s1_re) * PROD_W'(s1_s);
      s2_last <= s1_last;
    end
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_acc_re <= ACC_W'(s2_rc) + ACC_W'(s2_is);
      s3_acc_im <= ACC_W'(s2_ic) - ACC_W'(s2_rs);
      s3_last   <= s2_last;
    end
  end

  // round to nearest, ties up, then clip to the sample range
  always_comb begin
    round_re = s3_acc_re + ROUND_HALF;
    round_im = s3_acc_im + ROUND_HALF;
    q_re     = Q_W'(round_re >>> COEF_FRAC);
    q_im     = Q_W'(round_im >>> COEF_FRAC);
    priority if (q_re > SAT_HI) begin
      sat_re = SAMPLE_BITS'(SAT_HI);
    end else if (q_re < SAT_LO) begin
      sat_re = SAMPLE_BITS'(SAT_LO);
    end else begin
      sat_re = SAMPLE_BITS'(q_re);
    end
    priority if (q_im > SAT_HI) begin
      sat_im = SAMPLE_BITS'(SAT_HI);
    end else if (q_im < SAT_LO) begin
      sat_im = SAMPLE_BITS'(SAT_LO);
    end else begin
      sat_im = SAMPLE_BITS'(q_im);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_en) begin
      result.shifted_re     <= sat_re;
      result.shifted_im     <= sat_im;
      result.last_of_volume <= s3_last;
    end
  end

endmodule

### sv/fvps_checker.sv
// port-level checker for the fourier volume phase shift core, bound to the top level
module fvps_checker
  import fvps_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // a stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // the input only backs up after the output was stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> $past(result_valid && result_stall))
    else $error("sample_stall without a stalled result");

  // with the output draining, the queue never stays full, so sample_stall drops
  a_no_stall_drain: assert property (@(posedge clk) disable iff (rst)
    !result_stall |=> !sample_stall)
    else $error("sample_stall while results drain");

endmodule

bind fourier_volume_phase_shift_core fvps_checker u_fvps_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
